// File: rtl/core/hog_gradient_orientation_bin_macros.svh
`ifndef HOG_GRADIENT_ORIENTATION_BIN_MACROS_SVH
`define HOG_GRADIENT_ORIENTATION_BIN_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define HOG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/hog_pkg.sv
package hog_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 9;
  localparam int MAG_W      = 13;
  localparam int BIN_W      = 4;
  localparam int TAN_W      = 35;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    GR_IDLE,
    GR_RD_A,
    GR_RD_B,
    GR_JOB1,
    GR_JOB2,
    GR_JOB3
  } grad_state_t;

  typedef enum logic [1:0] {
    EN_IDLE,
    EN_SQ,
    EN_RUN,
    EN_DONE
  } eng_state_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } grad_job_t;

  // bin boundary tangents, Q32, boundary k+1 for index k
  function automatic logic signed [TAN_W-1:0] bound_tan(input logic [2:0] idx);
    logic signed [TAN_W-1:0] t;
    case (idx)
      3'd0:    t = -35'sd11796930665;
      3'd1:    t = -35'sd5116582226;
      3'd2:    t = -35'sd2478069789;
      3'd3:    t = -35'sd755631623;
      3'd4:    t = 35'sd759431784;
      3'd5:    t = 35'sd2482984629;
      3'd6:    t = 35'sd5125507284;
      default: t = 35'sd11828495153;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/hog_ram.sv
module hog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/hog_grad.sv
module hog_grad (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [hog_pkg::DIM_W-1:0]  img_width,
  input  logic [hog_pkg::DIM_W-1:0]  img_height,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hog_pkg::PIX_W-1:0]  pixel_value,
  output hog_pkg::grad_job_t         job,
  output logic                       job_valid,
  input  logic                       job_ready
);
  import hog_pkg::*;

  grad_state_t state, state_next;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] pix, ncur, ocur, nnext, nprev, p1, p2;

  logic [DIM_W-1:0] w_use, h_use;
  logic             is_last_col, is_last_row;
  logic             need1, need2, need3, advance;

  logic [COL_W-1:0] newer_addr;
  logic             ram_we;
  logic [PIX_W-1:0] newer_rdata, older_rdata;

  function automatic logic signed [GRAD_W-1:0] diff9(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
    return $signed({1'b0, a} - {1'b0, b});
  endfunction

  always_comb begin
    if (img_width < DIM_W'(2)) w_use = DIM_W'(2);
    else if (img_width > DIM_W'(MAX_WIDTH)) w_use = DIM_W'(MAX_WIDTH);
    else w_use = img_width;
    if (img_height < DIM_W'(2)) h_use = DIM_W'(2);
    else if (img_height > DIM_W'(MAX_HEIGHT)) h_use = DIM_W'(MAX_HEIGHT);
    else h_use = img_height;
  end

  assign is_last_col = (DIM_W'(col) == w_use - DIM_W'(1));
  assign is_last_row = (DIM_W'(row) == h_use - DIM_W'(1));

  assign need1 = (row != '0);
  assign need2 = is_last_row && (col != '0);
  assign need3 = is_last_row && is_last_col;

  // older keeps row r-2, newer keeps row r-1; both rewritten at col in GR_RD_B
  assign newer_addr = (state == GR_RD_A) ? col + COL_W'(1) : col;
  assign ram_we     = (state == GR_RD_B);

  hog_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (ram_we),
    .addr  (newer_addr),
    .wdata (pix),
    .rdata (newer_rdata)
  );

  hog_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (ram_we),
    .addr  (col),
    .wdata (ncur),
    .rdata (older_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    job        = '0;
    advance    = 1'b0;
    unique case (state)
      GR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = GR_RD_A;
      end
      GR_RD_A: state_next = GR_RD_B;
      GR_RD_B: state_next = GR_JOB1;
      GR_JOB1: begin
        if (col == '0) job.gx = diff9(nnext, ncur);
        else if (is_last_col) job.gx = diff9(ncur, nprev);
        else job.gx = diff9(nnext, nprev);
        job.gy    = (row == ROW_W'(1)) ? diff9(pix, ncur) : diff9(pix, ocur);
        job_valid = need1;
        if (!need1 || job_ready) state_next = GR_JOB2;
      end
      GR_JOB2: begin
        job.gx    = (col == COL_W'(1)) ? diff9(pix, p1) : diff9(pix, p2);
        job.gy    = diff9(p1, nprev);
        job_valid = need2;
        if (!need2 || job_ready) state_next = GR_JOB3;
      end
      GR_JOB3: begin
        job.gx    = diff9(pix, p1);
        job.gy    = diff9(pix, ncur);
        job.last  = 1'b1;
        job_valid = need3;
        if (!need3 || job_ready) begin
          advance    = 1'b1;
          state_next = GR_IDLE;
        end
      end
      default: state_next = GR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (is_last_col) begin
        col <= '0;
        row <= is_last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pix <= pixel_value;
    if (state == GR_RD_A) begin
      ncur <= newer_rdata;
      ocur <= older_rdata;
    end
    if (state == GR_RD_B) nnext <= newer_rdata;
    if (advance) begin
      p2    <= p1;
      p1    <= pix;
      nprev <= ncur;
    end
  end

endmodule

// File: rtl/core/hog_feat.sv
module hog_feat (
  input  logic                              clk,
  input  logic                              rst,
  input  hog_pkg::grad_job_t                job,
  input  logic                              job_valid,
  output logic                              job_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hog_pkg::GRAD_W-1:0] gradient_x,
  output logic signed [hog_pkg::GRAD_W-1:0] gradient_y,
  output logic [hog_pkg::MAG_W-1:0]         magnitude,
  output logic [hog_pkg::BIN_W-1:0]         orientation_bin,
  output logic                              last_of_frame
);
  import hog_pkg::*;

  localparam int SQ_W   = 25;
  localparam int R_W    = 26;
  localparam int D_W    = 19;
  localparam int PROD_W = TAN_W + D_W;
  localparam int CMP_W  = PROD_W + 1;
  localparam logic [3:0] LAST_STEP = 4'd12;
  localparam logic [3:0] NUM_BOUNDS = 4'd8;

  eng_state_t st, st_next;

  grad_job_t              cur;
  logic [SQ_W-1:0]        sq_v;
  logic [R_W-1:0]         sq_r;
  logic [3:0]             step;
  logic signed [D_W-1:0]  dval, numv;
  logic signed [PROD_W-1:0] prod;
  logic [BIN_W-1:0]       bin;

  logic signed [17:0]     gx2, gy2;
  logic [17:0]            sqsum;
  logic signed [D_W-1:0]  gx_ext, gy_ext;
  logic [R_W-1:0]         sq_bit, trial;
  logic signed [CMP_W-1:0] lhs, rhs;
  logic                   hit, load;

  assign gx2    = cur.gx * cur.gx;
  assign gy2    = cur.gy * cur.gy;
  assign sqsum  = 18'(gx2) + 18'(gy2);
  assign gx_ext = D_W'(cur.gx);
  assign gy_ext = D_W'(cur.gy);

  assign sq_bit = R_W'(1) << {(LAST_STEP - step), 1'b0};
  assign trial  = sq_r + sq_bit;

  assign lhs = $signed({numv, 32'd0});
  assign rhs = prod;
  assign hit = (dval > 0) ? (lhs >= rhs) : (lhs <= rhs);

  assign load      = (st == EN_DONE) && (!out_valid || out_ready);
  assign job_ready = (st == EN_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= EN_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      EN_IDLE: if (job_valid) st_next = EN_SQ;
      EN_SQ:   st_next = EN_RUN;
      EN_RUN:  if (step == LAST_STEP) st_next = EN_DONE;
      EN_DONE: if (load) st_next = EN_IDLE;
      default: st_next = EN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st == EN_IDLE && job_valid) cur <= job;
    if (st == EN_SQ) begin
      sq_v <= {sqsum[16:0], 8'd0};
      sq_r <= '0;
      step <= '0;
      dval <= gx_ext * D_W'(1000) + D_W'(1);
      numv <= gy_ext * D_W'(1000);
      bin  <= '0;
    end
    if (st == EN_RUN) begin
      step <= step + 4'd1;
      if ({1'b0, sq_v} >= trial) begin
        sq_v <= sq_v - trial[SQ_W-1:0];
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      if (step < NUM_BOUNDS) prod <= bound_tan(step[2:0]) * dval;
      if (step != '0 && step <= NUM_BOUNDS && hit) bin <= bin + BIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gradient_x      <= cur.gx;
      gradient_y      <= cur.gy;
      magnitude       <= sq_r[MAG_W-1:0];
      orientation_bin <= bin;
      last_of_frame   <= cur.last;
    end
  end

endmodule

// File: rtl/core/hog_gradient_orientation_bin.sv
// Gradient magnitude and nine-bin unsigned orientation for 8-bit grayscale frames in
// raster order. Results for a row come out while the next row streams in; the last
// row is flushed as it arrives, and its final result carries last_of_frame. Frame size
// is set by image_width (0x0) and image_height (0x4), clamped to 2..1024; any register
// write restarts the frame. Each pixel passes through the line-memory read/modify/write
// sequencer (GR_RD_A, GR_RD_B) and then one slot per possible result (GR_JOB1..3), and
// hands each of its results to one shared unit that runs a 13-step square root alongside
// 8 bound compares. That unit takes a new result only when idle, and the next pixel is
// taken only once the last slot of the current one is through, so output stalls hold
// back the input.
module hog_gradient_orientation_bin (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hog_pkg::PIX_W-1:0]         pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hog_pkg::GRAD_W-1:0] gradient_x,
  output logic signed [hog_pkg::GRAD_W-1:0] gradient_y,
  output logic [hog_pkg::MAG_W-1:0]         magnitude,
  output logic [hog_pkg::BIN_W-1:0]         orientation_bin,
  output logic                              last_of_frame
);
  import hog_pkg::*;

  logic [DIM_W-1:0] img_width, img_height;
  logic             cfg_wr;
  grad_job_t        job;
  logic             job_valid, job_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= DIM_W'(MAX_WIDTH);
      img_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  img_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: img_height <= pwdata[DIM_W-1:0];
        default:    img_width  <= img_width;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-DIM_W){1'b0}}, img_height}
                                           : {{(32-DIM_W){1'b0}}, img_width};

  hog_grad u_grad (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_wr),
    .img_width   (img_width),
    .img_height  (img_height),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .job         (job),
    .job_valid   (job_valid),
    .job_ready   (job_ready)
  );

  hog_feat u_feat (
    .clk             (clk),
    .rst             (rst),
    .job             (job),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .gradient_x      (gradient_x),
    .gradient_y      (gradient_y),
    .magnitude       (magnitude),
    .orientation_bin (orientation_bin),
    .last_of_frame   (last_of_frame)
  );

endmodule

// File: rtl/core/hog_checker.sv
`include "hog_gradient_orientation_bin_macros.svh"

module hog_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hog_pkg::GRAD_W-1:0] gradient_x,
  input logic signed [hog_pkg::GRAD_W-1:0] gradient_y,
  input logic [hog_pkg::MAG_W-1:0]         magnitude,
  input logic [hog_pkg::BIN_W-1:0]         orientation_bin,
  input logic                              last_of_frame
);
  import hog_pkg::*;

  logic [2*GRAD_W+MAG_W+BIN_W:0] res_bus;

  assign res_bus = {gradient_x, gradient_y, magnitude, orientation_bin, last_of_frame};

  `HOG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped")
  `HOG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(res_bus), "result changed")
  `HOG_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready, "back to back take")
  `HOG_ASSERT_NOW(a_out_range, out_valid, orientation_bin <= 4'd8 && magnitude <= 13'd5769, "range")

endmodule

bind hog_gradient_orientation_bin hog_checker u_hog_checker (.*);
